// File: rtl/glb_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the greedy line breaker.
// Used by glb_ctrl, glb_dp and greedy_line_breaker; depends on nothing.
package glb_pkg;

   localparam int unsigned WIDTH_BITS = 22;

   typedef struct packed {
      logic [15:0]        glyph_id;
      logic [15:0]        advance;
      logic signed [15:0] glyph_dy;
      logic               break_after;
      logic               is_space;
      logic               hard_break;
      logic               end_of_block;
   } req_type;

   typedef struct packed {
      logic [15:0]           out_glyph;
      logic [WIDTH_BITS-1:0] x_offset;
      logic signed [15:0]    out_dy;
      logic [15:0]           line_number;
      logic                  line_end;
      logic                  overflow;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic        spc;
      logic        brk;
      logic [15:0] y;
      logic [15:0] adv;
      logic [15:0] glyph;
   } entry_type;

   localparam logic [1:0] EMIT_SRC_COUNT = 2'd0;
   localparam logic [1:0] EMIT_SRC_HI    = 2'd1;
   localparam logic [1:0] EMIT_SRC_ONE   = 2'd2;

   typedef struct packed {
      logic       accept;
      logic       append;
      logic       trim_init;
      logic       trim_rd;
      logic       trim_dec;
      logic       skip_init;
      logic       skip_rd;
      logic       skip_inc;
      logic       drop;
      logic       scan_rd;
      logic       scan_acc;
      logic       emit_init;
      logic [1:0] emit_src;
      logic       emit_ovf;
      logic       emit_rd;
      logic       emit_put;
      logic       line_done;
      logic       clear;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic hard;
      logic eob;
      logic over;
      logic bv;
      logic bp_lt;
      logic cnt_zero;
      logic cnt_one;
      logic cnt_full;
      logic hi_zero;
      logic rd_space;
      logic t_lt_cnt;
      logic i_lt_cnt;
      logic i_lt_hi;
      logic can_put;
      logic pend_v;
   } sts_type;

endpackage

// File: rtl/greedy_line_breaker.sv
`timescale 1ns / 1ps
// Greedy line breaker: buffers glyphs of the current line and emits placed
// glyphs line by line. Top level; depends on glb_pkg, glb_ctrl, glb_dp.
//
// Usage:
//  req_*: one glyph or hard break per transfer (valid/stall, req_data).
//  rsp_*: one placed glyph per transfer; last marks the final result of an
//         input transfer. Inputs that place nothing produce no transfer.
//  csr_*: write of line_width; always ready, write only while idle.
// Flow: req_stall is high whenever the sequencer is not idle, so a new input
//  is taken only after the sequencer has finished the previous one. Emission
//  and the width flush (trim, skip, tail rescan) step one entry at a time,
//  paced by the single registered read port of the line store.
// The line store is a ring: dropping a flushed head moves a base pointer,
//  nothing is copied.
// Reset clears the line, the line counter and line_width; no clearing pass.
// A stall on rsp_* holds the output register; the engine keeps one more
//  result staged and then waits.
module greedy_line_breaker #(
   parameter int unsigned LINE_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  glb_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output glb_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [glb_pkg::WIDTH_BITS-1:0] csr_data
);
   glb_pkg::cmd_type cmd;
   glb_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   glb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   glb_dp #(.LINE_DEPTH(LINE_DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule

// File: rtl/glb_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module glb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/glb_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the line breaker: walks append, flush, rescan and emission.
// Depends on glb_pkg for the command and status structs.
module glb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  glb_pkg::sts_type sts,
   output glb_pkg::cmd_type cmd
);
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_START    = 4'd1;
   localparam logic [3:0] S_CHECK    = 4'd2;
   localparam logic [3:0] S_TRIM_RD  = 4'd3;
   localparam logic [3:0] S_TRIM_CHK = 4'd4;
   localparam logic [3:0] S_SKIP     = 4'd5;
   localparam logic [3:0] S_SKIP_RD  = 4'd6;
   localparam logic [3:0] S_SKIP_CHK = 4'd7;
   localparam logic [3:0] S_DROP     = 4'd8;
   localparam logic [3:0] S_SCAN_RD  = 4'd9;
   localparam logic [3:0] S_SCAN_ACC = 4'd10;
   localparam logic [3:0] S_EMIT_RD  = 4'd11;
   localparam logic [3:0] S_EMIT_PUT = 4'd12;
   localparam logic [3:0] S_EMIT_END = 4'd13;
   localparam logic [3:0] S_EOB      = 4'd14;
   localparam logic [3:0] S_FINISH   = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [3:0] ret_ff, ret_in;
   logic       clr_ff, clr_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      clr_in   = clr_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_START;
            end
         end
         S_START: begin
            if (sts.hard) begin
               if (!sts.cnt_zero) begin
                  cmd.emit_init = 1'b1;
                  cmd.emit_src  = glb_pkg::EMIT_SRC_COUNT;
                  clr_in        = 1'b1;
                  ret_in        = S_EOB;
                  state_in      = S_EMIT_RD;
               end else begin
                  state_in = S_EOB;
               end
            end else begin
               cmd.append = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.over && sts.bv && sts.bp_lt) begin
               cmd.trim_init = 1'b1;
               state_in      = S_TRIM_RD;
            end else if (sts.over && !sts.bv && sts.cnt_one) begin
               cmd.emit_init = 1'b1;
               cmd.emit_src  = glb_pkg::EMIT_SRC_ONE;
               clr_in        = 1'b1;
               ret_in        = S_CHECK;
               state_in      = S_EMIT_RD;
            end else if (sts.cnt_full) begin
               cmd.emit_init = 1'b1;
               cmd.emit_src  = glb_pkg::EMIT_SRC_COUNT;
               cmd.emit_ovf  = 1'b1;
               clr_in        = 1'b1;
               ret_in        = S_CHECK;
               state_in      = S_EMIT_RD;
            end else begin
               state_in = S_EOB;
            end
         end
         S_TRIM_RD: begin
            if (sts.hi_zero) begin
               state_in = S_SKIP;
            end else begin
               cmd.trim_rd = 1'b1;
               state_in    = S_TRIM_CHK;
            end
         end
         S_TRIM_CHK: begin
            if (sts.rd_space) begin
               cmd.trim_dec = 1'b1;
               state_in     = S_TRIM_RD;
            end else begin
               cmd.emit_init = 1'b1;
               cmd.emit_src  = glb_pkg::EMIT_SRC_HI;
               clr_in        = 1'b0;
               ret_in        = S_SKIP;
               state_in      = S_EMIT_RD;
            end
         end
         S_SKIP: begin
            cmd.skip_init = 1'b1;
            state_in      = S_SKIP_RD;
         end
         S_SKIP_RD: begin
            if (sts.t_lt_cnt) begin
               cmd.skip_rd = 1'b1;
               state_in    = S_SKIP_CHK;
            end else begin
               state_in = S_DROP;
            end
         end
         S_SKIP_CHK: begin
            if (sts.rd_space) begin
               cmd.skip_inc = 1'b1;
               state_in     = S_SKIP_RD;
            end else begin
               state_in = S_DROP;
            end
         end
         S_DROP: begin
            cmd.drop = 1'b1;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if (sts.i_lt_cnt) begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_ACC;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_SCAN_ACC: begin
            cmd.scan_acc = 1'b1;
            state_in     = S_SCAN_RD;
         end
         S_EMIT_RD: begin
            if (sts.i_lt_hi) begin
               cmd.emit_rd = 1'b1;
               state_in    = S_EMIT_PUT;
            end else begin
               state_in = S_EMIT_END;
            end
         end
         S_EMIT_PUT: begin
            if (sts.can_put) begin
               cmd.emit_put = 1'b1;
               state_in     = S_EMIT_RD;
            end
         end
         S_EMIT_END: begin
            cmd.line_done = 1'b1;
            cmd.clear     = clr_ff;
            state_in      = ret_ff;
         end
         S_EOB: begin
            if (sts.eob && !sts.cnt_zero) begin
               cmd.emit_init = 1'b1;
               cmd.emit_src  = glb_pkg::EMIT_SRC_COUNT;
               clr_in        = 1'b1;
               ret_in        = S_FINISH;
               state_in      = S_EMIT_RD;
            end else begin
               cmd.clear = sts.eob;
               state_in  = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!sts.pend_v || sts.can_put) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         clr_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         clr_ff   <= clr_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
endmodule

// File: rtl/glb_dp.sv
`timescale 1ns / 1ps
// Datapath of the line breaker: ring-buffered line store, width and break
// tracking, result staging. Depends on glb_pkg and glb_ram.
module glb_dp #(
   parameter int unsigned LINE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  glb_pkg::req_type req_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [glb_pkg::WIDTH_BITS-1:0] csr_data,
   input  glb_pkg::cmd_type cmd,
   output glb_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output glb_pkg::rsp_type rsp_data
);
   localparam int unsigned IW = $clog2(LINE_DEPTH);
   localparam int unsigned CW = $clog2(LINE_DEPTH + 1);
   localparam int unsigned WB = glb_pkg::WIDTH_BITS;
   localparam int unsigned EW = $bits(glb_pkg::entry_type);

   glb_pkg::req_type   item_ff, item_in;
   logic [IW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [WB-1:0]      sum_ff, sum_in;
   logic [IW-1:0]      bp_ff, bp_in;
   logic               bv_ff, bv_in;
   logic [15:0]        lines_ff, lines_in;
   logic [WB-1:0]      width_ff, width_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [CW-1:0]      t_ff, t_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      ehi_ff, ehi_in;
   logic               ovf_ff, ovf_in;
   logic [WB-1:0]      x_ff, x_in;
   glb_pkg::rsp_type   pend_ff, pend_in;
   logic               pend_v_ff, pend_v_in;
   glb_pkg::rsp_type   out_ff, out_in;
   logic               out_v_ff, out_v_in;

   glb_pkg::entry_type wentry, rentry;
   logic [EW-1:0]      rdata;
   logic [IW-1:0]      raddr, waddr;
   logic               re;
   logic               out_free;
   logic [CW-1:0]      bp_next;

   function automatic logic [IW-1:0] phys(input logic [IW-1:0] base,
                                          input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= (CW+1)'(LINE_DEPTH)) begin
         s = s - (CW+1)'(LINE_DEPTH);
      end
      return s[IW-1:0];
   endfunction

   assign bp_next  = CW'(bp_ff) + CW'(1);
   assign out_free = !out_v_ff || !rsp_stall;
   assign rentry   = glb_pkg::entry_type'(rdata);

   assign wentry.spc   = item_ff.is_space;
   assign wentry.brk   = item_ff.break_after;
   assign wentry.y     = item_ff.glyph_dy;
   assign wentry.adv   = item_ff.advance;
   assign wentry.glyph = item_ff.glyph_id;
   assign waddr        = phys(head_ff, count_ff);

   assign re = cmd.trim_rd | cmd.skip_rd | cmd.scan_rd | cmd.emit_rd;
   always_comb begin
      if (cmd.trim_rd) begin
         raddr = phys(head_ff, hi_ff - CW'(1));
      end else if (cmd.skip_rd) begin
         raddr = phys(head_ff, t_ff);
      end else begin
         raddr = phys(head_ff, i_ff);
      end
   end

   glb_ram #(.WIDTH(EW), .DEPTH(LINE_DEPTH)) u_store (
      .clock (clock),
      .we    (cmd.append),
      .waddr (waddr),
      .wdata (wentry),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      item_in   = item_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      bp_in     = bp_ff;
      bv_in     = bv_ff;
      lines_in  = lines_ff;
      width_in  = width_ff;
      hi_in     = hi_ff;
      t_in      = t_ff;
      i_in      = i_ff;
      ehi_in    = ehi_ff;
      ovf_in    = ovf_ff;
      x_in      = x_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      out_in    = out_ff;
      out_v_in  = out_v_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         width_in = csr_data;
      end
      if (cmd.accept) begin
         item_in = req_data;
      end
      if (cmd.append) begin
         count_in = count_ff + CW'(1);
         sum_in   = sum_ff + WB'(item_ff.advance);
         if (item_ff.break_after) begin
            bp_in = count_ff[IW-1:0];
            bv_in = 1'b1;
         end
      end
      if (cmd.trim_init) begin
         hi_in = bp_next;
      end
      if (cmd.trim_dec) begin
         hi_in = hi_ff - CW'(1);
      end
      if (cmd.skip_init) begin
         t_in = bp_next;
      end
      if (cmd.skip_inc) begin
         t_in = t_ff + CW'(1);
      end
      if (cmd.drop) begin
         head_in  = phys(head_ff, t_ff);
         count_in = count_ff - t_ff;
         sum_in   = '0;
         bp_in    = '0;
         bv_in    = 1'b0;
         i_in     = '0;
      end
      if (cmd.scan_acc) begin
         sum_in = sum_ff + WB'(rentry.adv);
         if (rentry.brk) begin
            bp_in = i_ff[IW-1:0];
            bv_in = 1'b1;
         end
         i_in = i_ff + CW'(1);
      end
      if (cmd.emit_init) begin
         i_in   = '0;
         x_in   = '0;
         ovf_in = cmd.emit_ovf;
         case (cmd.emit_src)
            glb_pkg::EMIT_SRC_HI:  ehi_in = hi_ff;
            glb_pkg::EMIT_SRC_ONE: ehi_in = CW'(1);
            default:               ehi_in = count_ff;
         endcase
      end
      if (cmd.emit_put) begin
         if (pend_v_ff) begin
            out_in   = pend_ff;
            out_v_in = 1'b1;
         end
         pend_in.out_glyph   = rentry.glyph;
         pend_in.x_offset    = x_ff;
         pend_in.out_dy      = rentry.y;
         pend_in.line_number = lines_ff;
         pend_in.line_end    = (i_ff + CW'(1)) == ehi_ff;
         pend_in.overflow    = ovf_ff;
         pend_in.last        = 1'b0;
         pend_v_in           = 1'b1;
         x_in = x_ff + WB'(rentry.adv);
         i_in = i_ff + CW'(1);
      end
      if (cmd.line_done) begin
         lines_in = lines_ff + 16'd1;
      end
      if (cmd.clear) begin
         count_in = '0;
         sum_in   = '0;
         bp_in    = '0;
         bv_in    = 1'b0;
      end
      if (cmd.finish && pend_v_ff) begin
         out_in      = pend_ff;
         out_in.last = 1'b1;
         out_v_in    = 1'b1;
         pend_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         bp_ff     <= '0;
         bv_ff     <= 1'b0;
         lines_ff  <= '0;
         width_ff  <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         bp_ff     <= bp_in;
         bv_ff     <= bv_in;
         lines_ff  <= lines_in;
         width_ff  <= width_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
      item_ff <= item_in;
      hi_ff   <= hi_in;
      t_ff    <= t_in;
      i_ff    <= i_in;
      ehi_ff  <= ehi_in;
      ovf_ff  <= ovf_in;
      x_ff    <= x_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign sts.hard     = item_ff.hard_break;
   assign sts.eob      = item_ff.end_of_block;
   assign sts.over     = sum_ff > width_ff;
   assign sts.bv       = bv_ff;
   assign sts.bp_lt    = bp_next < count_ff;
   assign sts.cnt_zero = count_ff == '0;
   assign sts.cnt_one  = count_ff == CW'(1);
   assign sts.cnt_full = count_ff == CW'(LINE_DEPTH);
   assign sts.hi_zero  = hi_ff == '0;
   assign sts.rd_space = rentry.spc;
   assign sts.t_lt_cnt = t_ff < count_ff;
   assign sts.i_lt_cnt = i_ff < count_ff;
   assign sts.i_lt_hi  = i_ff < ehi_ff;
   assign sts.can_put  = !pend_v_ff || out_free;
   assign sts.pend_v   = pend_v_ff;

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(LINE_DEPTH))
      else $error("line count beyond depth");
   a_break_inside: assert property (@(posedge clock) disable iff (reset)
      bv_ff |-> (CW'(bp_ff) < count_ff))
      else $error("break point outside the line");
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      CW'(head_ff) < CW'(LINE_DEPTH))
      else $error("ring head out of range");
   a_put_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_put && pend_v_ff) |-> out_free)
      else $error("result staged over a held result");
`endif
endmodule
